[design/cpf_pkg.sv]
package cpf_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int FRAC_BITS     = 16;
  localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
  localparam int COORD_W       = 32;
  localparam int DIF_W         = COORD_W + 1;
  localparam int MUL_W         = COORD_W + 1;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int RAD_W         = PROD_W + 2;
  localparam int ROOT_W        = RAD_W / 2;
  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 1;
  localparam int STATUS_W      = 2;

  // smallest raw distance above 1e-6 in the fixed point format
  localparam int EPS_RAW = ((1 << FRAC_BITS) + 999999) / 1000000;

  localparam logic [CFG_W-1:0] LOOK_RESET = CFG_W'(327680);
  localparam logic [CFG_W-1:0] TOL_RESET  = CFG_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b1;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_VEL    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_GOAL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CARROT = 2'd3;

  // x, y, z at index 0, 1, 2
  typedef logic [2:0][COORD_W-1:0] wp_t;

endpackage

[design/cpf_store.sv]
module cpf_store (
  input  logic                   clk,
  input  logic                   we,
  input  logic [cpf_pkg::ADDR_W-1:0] waddr,
  input  cpf_pkg::wp_t           wdata,
  input  logic [cpf_pkg::ADDR_W-1:0] raddr,
  output cpf_pkg::wp_t           rdata
);
  import cpf_pkg::*;

  wp_t mem [MAX_WAYPOINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/cpf_mul.sv]
module cpf_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cpf_pkg::MUL_W-1:0]  a,
  input  logic [cpf_pkg::MUL_W-1:0]  b,
  output logic                       done,
  output logic [cpf_pkg::PROD_W-1:0] prod
);
  import cpf_pkg::*;

  localparam int CW = $clog2(MUL_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [MUL_W-1:0] a_r;
  logic [MUL_W-1:0] acc_r;
  logic [MUL_W-1:0] b_r;
  logic [MUL_W:0]   sum;

  // one multiplier bit per cycle, low product bits shift into b_r
  assign sum  = {1'b0, acc_r} + (b_r[0] ? {1'b0, a_r} : '0);
  assign done = done_r;
  assign prod = {acc_r, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MUL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= sum[MUL_W:1];
      b_r   <= {sum[0], b_r[MUL_W-1:1]};
    end
  end

endmodule

[design/cpf_sqrt.sv]
module cpf_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cpf_pkg::RAD_W-1:0]  rad,
  output logic                       done,
  output logic [cpf_pkg::ROOT_W-1:0] root
);
  import cpf_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);
  localparam int RW = ROOT_W + 2;

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [RW-1:0]     rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RW-1:0]     rem_s;
  logic [RW-1:0]     trial;
  logic              fit;

  // restoring square root, two radicand bits per cycle
  assign rem_s = {rem_r[RW-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign fit   = rem_s >= trial;
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= fit ? rem_s - trial : rem_s;
      root_r <= {root_r[ROOT_W-2:0], fit};
    end
  end

endmodule

[design/cpf_div.sv]
module cpf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cpf_pkg::PROD_W-1:0] num,
  input  logic [cpf_pkg::ROOT_W-1:0] den,
  output logic                       done,
  output logic [cpf_pkg::PROD_W-1:0] quot
);
  import cpf_pkg::*;

  localparam int CW = $clog2(PROD_W + 1);
  localparam int RW = ROOT_W + 1;

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [PROD_W-1:0] num_r;
  logic [ROOT_W-1:0] den_r;
  logic [RW-1:0]     rem_r;
  logic [PROD_W-1:0] quot_r;
  logic [RW-1:0]     rem_s;
  logic              fit;

  // restoring division, one quotient bit per cycle
  assign rem_s = {rem_r[RW-2:0], num_r[PROD_W-1]};
  assign fit   = rem_s >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r  <= {num_r[PROD_W-2:0], 1'b0};
      rem_r  <= fit ? rem_s - {1'b0, den_r} : rem_s;
      quot_r <= {quot_r[PROD_W-2:0], fit};
    end
  end

endmodule

[design/carrot_path_follower.sv]
// Pure-pursuit path follower over a store of up to 64 waypoints (Q16.16). A load item
// is taken without leaving the idle state, so the block stays ready. An update item runs
// longer the more waypoints it skips and segments it measures, and longer still when
// the carrot falls inside a segment; status results end earlier. Its time is set by one
// shared bit-serial multiplier, a two-bit-per-cycle square root and a one-bit-per-cycle
// divider that all steps go through in turn, plus the registered reads of the waypoint
// memory, and it grows while a stalled result still holds the output register. A
// finished result waits in an output register while the next item is taken.
module carrot_path_follower (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpf_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic                              in_new_path,
  input  logic signed [31:0]                in_waypoint_x,
  input  logic signed [31:0]                in_waypoint_y,
  input  logic signed [31:0]                in_waypoint_z,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic signed [31:0]                in_pos_z,
  input  logic signed [31:0]                in_vel_x,
  input  logic signed [31:0]                in_vel_y,
  input  logic signed [31:0]                in_vel_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cpf_pkg::STATUS_W-1:0]      out_status,
  output logic signed [31:0]                out_cmd_vel_x,
  output logic signed [31:0]                out_cmd_vel_y,
  output logic signed [31:0]                out_cmd_vel_z,
  output logic [6:0]                        out_target_index
);
  import cpf_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_TOL_GO   = 5'd1;
  localparam logic [4:0] S_TOL_W    = 5'd2;
  localparam logic [4:0] S_SKIP_RD  = 5'd3;
  localparam logic [4:0] S_SKIP_DAT = 5'd4;
  localparam logic [4:0] S_SQ_GO    = 5'd5;
  localparam logic [4:0] S_SQ_W     = 5'd6;
  localparam logic [4:0] S_SKIP_CHK = 5'd7;
  localparam logic [4:0] S_LAST_RD  = 5'd8;
  localparam logic [4:0] S_LAST_DAT = 5'd9;
  localparam logic [4:0] S_A_RD     = 5'd10;
  localparam logic [4:0] S_A_DAT    = 5'd11;
  localparam logic [4:0] S_SEG      = 5'd12;
  localparam logic [4:0] S_B_DAT    = 5'd13;
  localparam logic [4:0] S_SQRT_GO  = 5'd14;
  localparam logic [4:0] S_SQRT_W   = 5'd15;
  localparam logic [4:0] S_SEG_CHK  = 5'd16;
  localparam logic [4:0] S_CAR_GO   = 5'd17;
  localparam logic [4:0] S_CAR_MW   = 5'd18;
  localparam logic [4:0] S_CAR_DW   = 5'd19;
  localparam logic [4:0] S_DIST_SET = 5'd20;
  localparam logic [4:0] S_DIST_CHK = 5'd21;
  localparam logic [4:0] S_SPD_CHK  = 5'd22;
  localparam logic [4:0] S_ST_GO    = 5'd23;
  localparam logic [4:0] S_ST_MW    = 5'd24;
  localparam logic [4:0] S_ST_DW    = 5'd25;
  localparam logic [4:0] S_EMIT     = 5'd26;

  logic [4:0]               state_r;
  logic [4:0]               ret_r;
  logic [4:0]               ret2_r;
  logic [1:0]               k_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cur_r;
  logic [CNT_W-1:0]         seg_r;
  logic [CFG_W-1:0]         look_r;
  logic [CFG_W-1:0]         tol_r;
  logic [2*CFG_W-1:0]       tol2_r;
  logic [CFG_W-1:0]         remain_r;
  logic [ROOT_W-1:0]        len_r;
  logic [ROOT_W-1:0]        dist_r;
  logic [MUL_W-1:0]         spd_r;
  logic [RAD_W-1:0]         acc_r;
  wp_t                      pos_r, vel_r, a_r, b_r, c_r;
  logic [2:0][DIF_W-1:0]    dif_r;
  logic [STATUS_W-1:0]      res_status_r;
  wp_t                      res_cmd_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  wp_t                      out_cmd_r;
  logic [CNT_W-1:0]         out_idx_r;

  logic                     in_acc;
  logic [CNT_W-1:0]         load_base;
  logic                     st_we;
  logic [ADDR_W-1:0]        st_raddr;
  wp_t                      st_wdata, st_rdata;

  logic                     mul_start, mul_done;
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        mul_prod;
  logic                     sq_start, sq_done;
  logic [ROOT_W-1:0]        sq_root;
  logic                     div_start, div_done;
  logic [ROOT_W-1:0]        div_den;
  logic [PROD_W-1:0]        div_quot;
  logic [DIF_W-1:0]         dif_k_mag;
  logic [COORD_W+1:0]       car_base, car_q, car_sum;
  logic [COORD_W-1:0]       steer_v;

  function automatic logic [DIF_W-1:0] sub33(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    sub33 = {x[COORD_W-1], x} - {y[COORD_W-1], y};
  endfunction

  function automatic logic [DIF_W-1:0] mag33(input logic [DIF_W-1:0] d);
    mag33 = d[DIF_W-1] ? (~d + 1'b1) : d;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_base = in_new_path ? '0 : cnt_r;
  assign st_we     = in_acc && (in_kind == KIND_LOAD) && (load_base < CNT_W'(MAX_WAYPOINTS));
  assign st_wdata  = {in_waypoint_z, in_waypoint_y, in_waypoint_x};

  always_comb begin
    case (state_r)
      S_LAST_RD: st_raddr = ADDR_W'(cnt_r - 1'b1);
      S_A_RD:    st_raddr = seg_r[ADDR_W-1:0];
      S_SEG:     st_raddr = ADDR_W'(seg_r + 1'b1);
      default:   st_raddr = cur_r[ADDR_W-1:0];
    endcase
  end

  cpf_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (load_base[ADDR_W-1:0]),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign dif_k_mag = mag33(dif_r[k_r]);
  assign mul_start = (state_r == S_TOL_GO) || (state_r == S_SQ_GO) ||
                     (state_r == S_CAR_GO) || (state_r == S_ST_GO);

  always_comb begin
    case (state_r)
      S_TOL_GO: begin
        mul_a = {2'b00, tol_r};
        mul_b = {2'b00, tol_r};
      end
      S_CAR_GO: begin
        mul_a = dif_k_mag;
        mul_b = {2'b00, remain_r};
      end
      S_ST_GO: begin
        mul_a = spd_r;
        mul_b = dif_k_mag;
      end
      default: begin
        mul_a = dif_k_mag;
        mul_b = dif_k_mag;
      end
    endcase
  end

  cpf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign sq_start = (state_r == S_SQRT_GO);

  cpf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (acc_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign div_start = mul_done && ((state_r == S_CAR_MW) || (state_r == S_ST_MW));
  assign div_den   = (state_r == S_CAR_MW) ? len_r : dist_r;

  cpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_prod),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // carrot component: segment start plus the truncated fraction of the segment
  assign car_base = {a_r[k_r][COORD_W-1], a_r[k_r][COORD_W-1], a_r[k_r]};
  assign car_q    = {1'b0, div_quot[COORD_W:0]};
  assign car_sum  = dif_r[k_r][DIF_W-1] ? car_base - car_q : car_base + car_q;

  // saturate the signed steering component
  always_comb begin
    if (dif_r[k_r][DIF_W-1]) begin
      if (|div_quot[PROD_W-1:COORD_W] || (div_quot[COORD_W-1] && |div_quot[COORD_W-2:0])) begin
        steer_v = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        steer_v = ~div_quot[COORD_W-1:0] + 1'b1;
      end
    end else begin
      if (|div_quot[PROD_W-1:COORD_W-1]) begin
        steer_v = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        steer_v = div_quot[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r <= LOOK_RESET;
      tol_r  <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOKAHEAD: look_r <= cfg_data;
        CFG_TOLERANCE: tol_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_kind == KIND_LOAD) begin
              if (in_new_path) begin
                cur_r <= '0;
              end
              if (st_we) begin
                cnt_r <= load_base + 1'b1;
              end else begin
                cnt_r <= load_base;
              end
            end else begin
              pos_r     <= {in_pos_z, in_pos_y, in_pos_x};
              vel_r     <= {in_vel_z, in_vel_y, in_vel_x};
              res_cmd_r <= '0;
              if (cnt_r == '0) begin
                res_status_r <= ST_EMPTY;
                state_r      <= S_EMIT;
              end else begin
                state_r <= S_TOL_GO;
              end
            end
          end
        end
        S_TOL_GO: state_r <= S_TOL_W;
        S_TOL_W: begin
          if (mul_done) begin
            tol2_r  <= mul_prod[2*CFG_W-1:0];
            state_r <= S_SKIP_RD;
          end
        end
        S_SKIP_RD: begin
          if (cur_r >= cnt_r) begin
            res_status_r <= ST_GOAL;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_SKIP_DAT;
          end
        end
        S_SKIP_DAT: begin
          for (int j = 0; j < 3; j++) begin
            dif_r[j] <= sub33(st_rdata[j], pos_r[j]);
          end
          acc_r   <= '0;
          k_r     <= '0;
          ret_r   <= S_SKIP_CHK;
          state_r <= S_SQ_GO;
        end
        S_SQ_GO: state_r <= S_SQ_W;
        S_SQ_W: begin
          if (mul_done) begin
            acc_r <= acc_r + {2'b00, mul_prod};
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= ret_r;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_SQ_GO;
            end
          end
        end
        S_SKIP_CHK: begin
          if (acc_r < {{(RAD_W-2*CFG_W){1'b0}}, tol2_r}) begin
            cur_r   <= cur_r + 1'b1;
            state_r <= S_SKIP_RD;
          end else begin
            state_r <= S_LAST_RD;
          end
        end
        S_LAST_RD: state_r <= S_LAST_DAT;
        S_LAST_DAT: begin
          c_r      <= st_rdata;
          seg_r    <= cur_r;
          remain_r <= look_r;
          state_r  <= S_A_RD;
        end
        S_A_RD: state_r <= S_A_DAT;
        S_A_DAT: begin
          a_r     <= st_rdata;
          state_r <= S_SEG;
        end
        S_SEG: begin
          if (seg_r + 1'b1 >= cnt_r) begin
            state_r <= S_DIST_SET;
          end else begin
            state_r <= S_B_DAT;
          end
        end
        S_B_DAT: begin
          b_r <= st_rdata;
          for (int j = 0; j < 3; j++) begin
            dif_r[j] <= sub33(st_rdata[j], a_r[j]);
          end
          acc_r   <= '0;
          k_r     <= '0;
          ret_r   <= S_SQRT_GO;
          ret2_r  <= S_SEG_CHK;
          state_r <= S_SQ_GO;
        end
        S_SQRT_GO: state_r <= S_SQRT_W;
        S_SQRT_W: begin
          if (sq_done) begin
            state_r <= ret2_r;
          end
        end
        S_SEG_CHK: begin
          len_r <= sq_root;
          if ({{(ROOT_W-CFG_W){1'b0}}, remain_r} < sq_root) begin
            k_r     <= '0;
            state_r <= S_CAR_GO;
          end else begin
            // here the segment length does not exceed the remaining lookahead
            remain_r <= remain_r - sq_root[CFG_W-1:0];
            a_r      <= b_r;
            seg_r    <= seg_r + 1'b1;
            state_r  <= S_SEG;
          end
        end
        S_CAR_GO: state_r <= S_CAR_MW;
        S_CAR_MW: begin
          if (mul_done) begin
            state_r <= S_CAR_DW;
          end
        end
        S_CAR_DW: begin
          if (div_done) begin
            c_r[k_r] <= car_sum[COORD_W-1:0];
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_DIST_SET;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_CAR_GO;
            end
          end
        end
        S_DIST_SET: begin
          for (int j = 0; j < 3; j++) begin
            dif_r[j] <= sub33(c_r[j], pos_r[j]);
          end
          acc_r   <= '0;
          k_r     <= '0;
          ret_r   <= S_SQRT_GO;
          ret2_r  <= S_DIST_CHK;
          state_r <= S_SQ_GO;
        end
        S_DIST_CHK: begin
          dist_r <= sq_root;
          if (sq_root < ROOT_W'(EPS_RAW) || sq_root == '0) begin
            res_status_r <= ST_CARROT;
            state_r      <= S_EMIT;
          end else begin
            for (int j = 0; j < 3; j++) begin
              dif_r[j] <= {vel_r[j][COORD_W-1], vel_r[j]};
            end
            acc_r   <= '0;
            k_r     <= '0;
            ret_r   <= S_SQRT_GO;
            ret2_r  <= S_SPD_CHK;
            state_r <= S_SQ_GO;
          end
        end
        S_SPD_CHK: begin
          spd_r <= sq_root[MUL_W-1:0];
          for (int j = 0; j < 3; j++) begin
            dif_r[j] <= sub33(c_r[j], pos_r[j]);
          end
          k_r     <= '0;
          state_r <= S_ST_GO;
        end
        S_ST_GO: state_r <= S_ST_MW;
        S_ST_MW: begin
          if (mul_done) begin
            state_r <= S_ST_DW;
          end
        end
        S_ST_DW: begin
          if (div_done) begin
            res_cmd_r[k_r] <= steer_v;
            if (k_r == 2'd2) begin
              k_r          <= '0;
              res_status_r <= ST_VEL;
              state_r      <= S_EMIT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_ST_GO;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_cmd_r    <= res_cmd_r;
            out_idx_r    <= cur_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_cmd_vel_x    = out_cmd_r[0];
  assign out_cmd_vel_y    = out_cmd_r[1];
  assign out_cmd_vel_z    = out_cmd_r[2];
  assign out_target_index = 7'(out_idx_r);

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= cnt_r)
    else $error("waypoint index beyond stored count");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_WAYPOINTS))
    else $error("waypoint count beyond store depth");

  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_UPDATE) |=> in_stall)
    else $error("update item did not start the sequencer");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_LOAD) |=> !in_stall)
    else $error("load item left the block busy");
`endif

endmodule

[tb/carrot_path_follower_tb.sv]
module carrot_path_follower_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpf_pkg::*;

  typedef struct {
    logic       kind;
    logic       new_path;
    int         wx, wy, wz;
    int         px, py, pz;
    int         vx, vy, vz;
  } path_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    int                  cvx, cvy, cvz;
    logic [6:0]          tidx;
  } steer_cmd_t;

  class steer_scoreboard;
    int             wpx[MAX_WAYPOINTS], wpy[MAX_WAYPOINTS], wpz[MAX_WAYPOINTS];
    int unsigned    wp_count, cur_idx;
    logic [CFG_W-1:0] look, tol;
    steer_cmd_t     expected_cmds[$];
    int             errors, n_items, n_cmds;
    int             st_seen[4];

    function new();
      wp_count = 0;
      cur_idx  = 0;
      look     = LOOK_RESET;
      tol      = TOL_RESET;
      errors   = 0;
      n_items  = 0;
      n_cmds   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_LOOKAHEAD) look = val;
      else if (idx == CFG_TOLERANCE) tol = val;
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function logic [127:0] sq3(longint a, longint b, longint c);
      logic [127:0] ma, mb, mc;
      ma = {64'd0, mag(a)};
      mb = {64'd0, mag(b)};
      mc = {64'd0, mag(c)};
      return ma * ma + mb * mb + mc * mc;
    endfunction

    function logic [63:0] isqrt(logic [127:0] s);
      logic [63:0] r, cand;
      r = 0;
      for (int b = 34; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if ({64'd0, cand} * {64'd0, cand} <= s) r = cand;
      end
      return r;
    endfunction

    function int steer_comp(logic [63:0] speed, longint d, logic [63:0] span);
      logic [127:0] n;
      logic [63:0]  q;
      n = {64'd0, speed} * {64'd0, mag(d)};
      q = 64'(n / {64'd0, span});
      if (d < 0) return q > 64'h8000_0000 ? 32'sh8000_0000 : int'(-longint'(q));
      return q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : int'(q);
    endfunction

    // works out the command for one update against the current path
    function steer_cmd_t follow(path_item_t it);
      steer_cmd_t   r;
      logic [127:0] s, tol2;
      longint       cx, cy, cz, sx, sy, sz, dx, dy, dz;
      logic [63:0]  remain, len, carrot_dist, speed;
      r = '{ST_VEL, 0, 0, 0, 7'd0};
      if (wp_count == 0) begin
        r.status = ST_EMPTY;
        r.tidx = 7'(cur_idx);
        return r;
      end
      tol2 = {97'd0, tol} * {97'd0, tol};
      while (cur_idx < wp_count) begin
        s = sq3(longint'(wpx[cur_idx]) - it.px, longint'(wpy[cur_idx]) - it.py,
                longint'(wpz[cur_idx]) - it.pz);
        if (s < tol2) cur_idx++;
        else break;
      end
      r.tidx = 7'(cur_idx);
      if (cur_idx >= wp_count) begin
        r.status = ST_GOAL;
        return r;
      end
      cx = wpx[wp_count-1];
      cy = wpy[wp_count-1];
      cz = wpz[wp_count-1];
      remain = {33'd0, look};
      for (int unsigned i = cur_idx; i + 1 < wp_count; i++) begin
        sx = longint'(wpx[i+1]) - wpx[i];
        sy = longint'(wpy[i+1]) - wpy[i];
        sz = longint'(wpz[i+1]) - wpz[i];
        len = isqrt(sq3(sx, sy, sz));
        if (remain < len) begin
          cx = wpx[i] + sx * longint'(remain) / longint'(len);
          cy = wpy[i] + sy * longint'(remain) / longint'(len);
          cz = wpz[i] + sz * longint'(remain) / longint'(len);
          break;
        end
        remain -= len;
      end
      dx = cx - it.px;
      dy = cy - it.py;
      dz = cz - it.pz;
      carrot_dist = isqrt(sq3(dx, dy, dz));
      if (carrot_dist < EPS_RAW || carrot_dist == 0) begin
        r.status = ST_CARROT;
        return r;
      end
      speed = isqrt(sq3(it.vx, it.vy, it.vz));
      r.cvx = steer_comp(speed, dx, carrot_dist);
      r.cvy = steer_comp(speed, dy, carrot_dist);
      r.cvz = steer_comp(speed, dz, carrot_dist);
      return r;
    endfunction

    function void note_item(path_item_t it);
      n_items++;
      if (it.kind == KIND_LOAD) begin
        if (it.new_path) begin
          wp_count = 0;
          cur_idx = 0;
        end
        if (wp_count < MAX_WAYPOINTS) begin
          wpx[wp_count] = it.wx;
          wpy[wp_count] = it.wy;
          wpz[wp_count] = it.wz;
          wp_count++;
        end
      end else begin
        expected_cmds.push_back(follow(it));
      end
    endfunction

    function void check_cmd(steer_cmd_t got);
      steer_cmd_t e;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result status=%0d idx=%0d", $time, got.status, got.tidx);
        errors++;
        return;
      end
      e = expected_cmds.pop_front();
      n_cmds++;
      st_seen[e.status]++;
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.cvx !== e.cvx) begin
        $display("%0t: cmd_vel_x exp %0d got %0d", $time, e.cvx, got.cvx);
        errors++;
      end
      if (got.cvy !== e.cvy) begin
        $display("%0t: cmd_vel_y exp %0d got %0d", $time, e.cvy, got.cvy);
        errors++;
      end
      if (got.cvz !== e.cvz) begin
        $display("%0t: cmd_vel_z exp %0d got %0d", $time, e.cvz, got.cvz);
        errors++;
      end
      if (got.tidx !== e.tidx) begin
        $display("%0t: target_index exp %0d got %0d", $time, e.tidx, got.tidx);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic                  in_new_path;
  logic signed [31:0]    in_waypoint_x, in_waypoint_y, in_waypoint_z;
  logic signed [31:0]    in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0]    in_vel_x, in_vel_y, in_vel_z;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   out_status;
  logic signed [31:0]    out_cmd_vel_x, out_cmd_vel_y, out_cmd_vel_z;
  logic [6:0]            out_target_index;

  steer_scoreboard sb;
  int tx_idle_pct, rx_idle_pct;

  carrot_path_follower u_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #1s;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_cmd('{out_status, out_cmd_vel_x, out_cmd_vel_y, out_cmd_vel_z, out_target_index});
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  task automatic send_item(path_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= it.kind;
    in_new_path   <= it.new_path;
    in_waypoint_x <= it.wx;
    in_waypoint_y <= it.wy;
    in_waypoint_z <= it.wz;
    in_pos_x      <= it.px;
    in_pos_y      <= it.py;
    in_pos_z      <= it.pz;
    in_vel_x      <= it.vx;
    in_vel_y      <= it.vy;
    in_vel_z      <= it.vz;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic finish_items();
    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic load_wp(logic np, int x, int y, int z);
    send_item('{KIND_LOAD, np, x, y, z, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom});
  endtask

  task automatic update(int x, int y, int z, int vx, int vy, int vz);
    send_item('{KIND_UPDATE, 1'($urandom), $urandom, $urandom, $urandom,
                x, y, z, vx, vy, vz});
  endtask

  function automatic int near(int c, int spread);
    return c + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic int rand_vel();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return near(0, 1 << 19);
    endcase
  endfunction

  // one path load followed by a few updates, most of them at or near its waypoints
  task automatic run_path();
    int n, spread, bx, by, bz, k;
    int px[$], py[$], pz[$];
    bit wide;
    wide = ($urandom_range(0, 9) == 0);
    n = ($urandom_range(0, 24) == 0) ? $urandom_range(62, 66) : $urandom_range(1, 8);
    spread = 1 << $urandom_range(14, 20);
    bx = near(0, 1 << 28);
    by = near(0, 1 << 28);
    bz = near(0, 1 << 28);
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        px.push_back($urandom); py.push_back($urandom); pz.push_back($urandom);
      end else begin
        bx = near(bx, spread); by = near(by, spread); bz = near(bz, spread);
        px.push_back(bx); py.push_back(by); pz.push_back(bz);
      end
      load_wp(i == 0, px[i], py[i], pz[i]);
    end
    if ($urandom_range(0, 9) == 0) load_wp(1'b0, $urandom, $urandom, $urandom);
    for (int u = $urandom_range(1, 6); u > 0; u--) begin
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 4))
        0: update($urandom, $urandom, $urandom, rand_vel(), rand_vel(), rand_vel());
        1: update(px[k], py[k], pz[k], rand_vel(), rand_vel(), rand_vel());
        default: update(near(px[k], spread), near(py[k], spread), near(pz[k], spread),
                        rand_vel(), rand_vel(), rand_vel());
      endcase
    end
  endtask

  initial begin
    int unsigned look_set[6], tol_set[6];
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD;
    in_new_path = 1'b0;
    {in_waypoint_x, in_waypoint_y, in_waypoint_z} = '0;
    {in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z} = '0;
    out_stall = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty path, extremes, goal reached
    update(0, 0, 0, 1 << 16, 0, 0);
    load_wp(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    load_wp(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    update(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
           32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    update(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    update(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
    load_wp(1'b1, 0, 0, 0);
    load_wp(1'b0, 10 << 16, 0, 0);
    load_wp(1'b0, 10 << 16, 10 << 16, 0);
    update(0, 0, 0, 1 << 16, 1 << 16, 0);
    update(3 << 16, 1 << 16, 0, -(2 << 16), 0, 1 << 16);
    update(10 << 16, 10 << 16, 0, 1 << 16, 0, 0);
    finish_items();
    // zero tolerance lets the carrot sit on the vehicle
    write_reg(CFG_TOLERANCE, '0);
    write_reg(CFG_LOOKAHEAD, '0);
    load_wp(1'b1, 5 << 16, -(3 << 16), 7);
    update(5 << 16, -(3 << 16), 7, 1 << 16, 0, 0);
    load_wp(1'b0, 9 << 16, -(3 << 16), 7);
    update(5 << 16, -(3 << 16), 7, 1 << 16, 0, 0);
    update(4 << 16, -(3 << 16), 7, 0, 1 << 16, 0);
    finish_items();

    look_set = '{327680, 0, 32'h7FFF_FFFF, 1 << 20, 65536, 3 << 18};
    tol_set  = '{65536, 0, 1 << 18, 32'h7FFF_FFFF, 1, 1 << 21};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_LOOKAHEAD, CFG_W'(look_set[ph] == 1 << 20 ? $urandom_range(1, 1 << 22)
                                                              : look_set[ph]));
      write_reg(CFG_TOLERANCE, CFG_W'(tol_set[ph]));
      tx_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 85 : 0;
      rx_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 27 : 0;
      while (sb.n_items < 250 * (ph + 1)) run_path();
      finish_items();
    end
    rx_idle_pct = 0;

    $display("items %0d, results %0d: vel %0d empty %0d goal %0d carrot-at-vehicle %0d",
             sb.n_items, sb.n_cmds, sb.st_seen[0], sb.st_seen[1], sb.st_seen[2],
             sb.st_seen[3]);
    $display("six register settings, mixed sender/receiver stall phases");
    if (sb.errors == 0 && sb.expected_cmds.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
